[design/psd_pkg.sv]
// Shared types, constants and register map of the speed PID with stall detection.
package psd_pkg;

    // Defaults for the top-level parameters
    localparam int SAMPLE_WIDTH_DEF    = 16;
    localparam int STALL_COUNT_MAX_DEF = 10000;

    // Fixed field widths
    localparam int GAIN_W      = 16;
    localparam int ES_W        = 24;
    localparam int ILIM_W      = 23;
    localparam int OLIM_W      = 15;
    localparam int THR_W       = 14;
    localparam int DRIVE_W     = 16;
    localparam int OUT_TDATA_W = ((DRIVE_W + 1 + 7) / 8) * 8;

    // Gains are Q8.8
    localparam int FRAC_BITS = 8;

    // Stall test: PCT_SCALE*|err| > STALL_PCT*|target|
    localparam int PCT_SCALE = 100;
    localparam int STALL_PCT = 85;
    // Detection runs only once the previous drive reaches out_limit / LIMIT_DIV
    localparam int LIMIT_DIV = 5;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 23;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_PROP_GAIN     = 3'd0;
    localparam t_cfg_idx REG_INTEG_GAIN    = 3'd1;
    localparam t_cfg_idx REG_DERIV_GAIN    = 3'd2;
    localparam t_cfg_idx REG_INTEG_LIMIT   = 3'd3;
    localparam t_cfg_idx REG_OUT_LIMIT     = 3'd4;
    localparam t_cfg_idx REG_LOCK_THRESH   = 3'd5;
    localparam t_cfg_idx REG_UNLOCK_THRESH = 3'd6;

    typedef struct packed {
        logic signed [GAIN_W-1:0] prop_gain;
        logic signed [GAIN_W-1:0] integ_gain;
        logic signed [GAIN_W-1:0] deriv_gain;
        logic [ILIM_W-1:0]        integ_limit;
        logic [OLIM_W-1:0]        out_limit;
        logic [THR_W-1:0]         lock_threshold;
        logic [THR_W-1:0]         unlock_threshold;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        prop_gain:        16'sd3072,
        integ_gain:       16'sd0,
        deriv_gain:       16'sd0,
        integ_limit:      23'd9000,
        out_limit:        15'd9000,
        lock_threshold:   14'd600,
        unlock_threshold: 14'd3600
    };

endpackage

[design/psd_cfg_regs.sv]
// Configuration register bank of the speed PID with stall detection.
module psd_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  psd_pkg::t_cfg_idx              i_cfg_index,
    input  logic [psd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output psd_pkg::t_cfg                  o_cfg
);

    psd_pkg::t_cfg r_cfg;
    psd_pkg::t_cfg n_cfg;

    // Decode the write into the addressed field, drop unknown indexes
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                psd_pkg::REG_PROP_GAIN: begin
                    n_cfg.prop_gain = i_cfg_data[psd_pkg::GAIN_W-1:0];
                end
                psd_pkg::REG_INTEG_GAIN: begin
                    n_cfg.integ_gain = i_cfg_data[psd_pkg::GAIN_W-1:0];
                end
                psd_pkg::REG_DERIV_GAIN: begin
                    n_cfg.deriv_gain = i_cfg_data[psd_pkg::GAIN_W-1:0];
                end
                psd_pkg::REG_INTEG_LIMIT: begin
                    n_cfg.integ_limit = i_cfg_data[psd_pkg::ILIM_W-1:0];
                end
                psd_pkg::REG_OUT_LIMIT: begin
                    n_cfg.out_limit = i_cfg_data[psd_pkg::OLIM_W-1:0];
                end
                psd_pkg::REG_LOCK_THRESH: begin
                    n_cfg.lock_threshold = i_cfg_data[psd_pkg::THR_W-1:0];
                end
                psd_pkg::REG_UNLOCK_THRESH: begin
                    n_cfg.unlock_threshold = i_cfg_data[psd_pkg::THR_W-1:0];
                end
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= psd_pkg::CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[design/pid_speed_with_stall_detect.sv]
// Top level of the positional speed PID with anti-windup and stall detection.
// Takes one measured/target sample pair per clock while s_axis_tready is high and
// returns one drive word per sample. Stage one forms the
// error and updates the clamped error sum; stage two holds the three gain
// products (one multiplier each); stage three sums them, scales by 1/256 with
// floor, clamps to the output limit and runs stall detection against the
// drive of the previous sample, which is what the output register still holds.
// A result that waits at the output does not block the stages behind it
// until they are full. Write configuration only while no sample is in flight.
module pid_speed_with_stall_detect #(
    parameter int SAMPLE_WIDTH    = psd_pkg::SAMPLE_WIDTH_DEF,
    parameter int STALL_COUNT_MAX = psd_pkg::STALL_COUNT_MAX_DEF,
    localparam int IN_TDATA_W     = ((2 * SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration write port
    input  logic                            i_cfg_wr_en,
    input  psd_pkg::t_cfg_idx               i_cfg_index,
    input  logic [psd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // Sample stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [IN_TDATA_W-1:0]           s_axis_tdata,  // measured, setpoint
    // Drive stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [psd_pkg::OUT_TDATA_W-1:0] m_axis_tdata   // drive, stalled
);

    localparam int SW     = SAMPLE_WIDTH;
    localparam int ERR_W  = SW + 1;
    localparam int DIF_W  = ERR_W + 1;
    localparam int SUM_W  = ((psd_pkg::ES_W > ERR_W) ? psd_pkg::ES_W : ERR_W) + 1;
    localparam int MAG_W  = ERR_W + 7;
    localparam int PP_W   = psd_pkg::GAIN_W + ERR_W;
    localparam int PI_W   = psd_pkg::GAIN_W + psd_pkg::ES_W;
    localparam int PD_W   = psd_pkg::GAIN_W + DIF_W;
    localparam int ACC_W  = psd_pkg::GAIN_W
                          + ((psd_pkg::ES_W > DIF_W) ? psd_pkg::ES_W : DIF_W) + 2;
    localparam int PD5_W  = psd_pkg::DRIVE_W + 3;
    localparam int CNT_W  = $clog2(STALL_COUNT_MAX + 1);
    localparam int PAD_W  = psd_pkg::OUT_TDATA_W - psd_pkg::DRIVE_W - 1;

    psd_pkg::t_cfg cfg;

    psd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Pipeline control: a stage loads when it is empty or its word moves on
    logic r_v1, r_v2, r_v3;
    logic en1, en2, en3, accept;

    assign en3           = !r_v3 || m_axis_tready;
    assign en2           = !r_v2 || en3;
    assign en1           = !r_v1 || en2;
    assign s_axis_tready = en1;
    assign accept        = s_axis_tvalid && en1;

    // ---------------- Stage 1: error, error sum, stall test ----------------
    logic signed [SW-1:0]           meas, tgt;
    logic signed [ERR_W-1:0]        err;
    logic signed [SUM_W-1:0]        esum_raw, ilim;
    logic signed [psd_pkg::ES_W-1:0] n_error_sum;
    logic signed [DIF_W-1:0]        diff;
    logic [ERR_W-1:0]               mag_err;
    logic [SW-1:0]                  mag_tgt;
    logic                           hit;

    logic signed [psd_pkg::ES_W-1:0] r_error_sum;
    logic signed [ERR_W-1:0]         r_prev_error;

    logic signed [ERR_W-1:0]         r_s1_err;
    logic signed [psd_pkg::ES_W-1:0] r_s1_esum;
    logic signed [DIF_W-1:0]         r_s1_diff;
    logic                            r_s1_hit, r_s1_tgt_nz;

    always_comb begin
        meas     = s_axis_tdata[SW-1:0];
        tgt      = s_axis_tdata[2*SW-1:SW];
        err      = ERR_W'(tgt) - ERR_W'(meas);
        esum_raw = SUM_W'(r_error_sum) + SUM_W'(err);
        ilim     = SUM_W'($signed({1'b0, cfg.integ_limit}));
        // Clamp the error sum symmetrically
        priority if (esum_raw > ilim) begin
            n_error_sum = psd_pkg::ES_W'(ilim);
        end else if (esum_raw < -ilim) begin
            n_error_sum = psd_pkg::ES_W'(-ilim);
        end else begin
            n_error_sum = psd_pkg::ES_W'(esum_raw);
        end
        diff    = DIF_W'(err) - DIF_W'(r_prev_error);
        mag_err = err[ERR_W-1] ? -err : err;
        mag_tgt = tgt[SW-1] ? -tgt : tgt;
        hit     = (MAG_W'(mag_err) * MAG_W'(psd_pkg::PCT_SCALE))
                > (MAG_W'(mag_tgt) * MAG_W'(psd_pkg::STALL_PCT));
    end

    // Advance error state on every accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_error_sum  <= '0;
            r_prev_error <= '0;
            r_v1         <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= accept;
            end
            if (accept) begin
                r_error_sum  <= n_error_sum;
                r_prev_error <= err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_err    <= err;
            r_s1_esum   <= n_error_sum;
            r_s1_diff   <= diff;
            r_s1_hit    <= hit;
            r_s1_tgt_nz <= (tgt != '0);
        end
    end

    // ---------------- Stage 2: gain products ----------------
    logic signed [PP_W-1:0] r_s2_prod_p;
    logic signed [PI_W-1:0] r_s2_prod_i;
    logic signed [PD_W-1:0] r_s2_prod_d;
    logic                   r_s2_hit, r_s2_tgt_nz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2 && r_v1) begin
            r_s2_prod_p <= PP_W'(cfg.prop_gain) * PP_W'(r_s1_err);
            r_s2_prod_i <= PI_W'(cfg.integ_gain) * PI_W'(r_s1_esum);
            r_s2_prod_d <= PD_W'(cfg.deriv_gain) * PD_W'(r_s1_diff);
            r_s2_hit    <= r_s1_hit;
            r_s2_tgt_nz <= r_s1_tgt_nz;
        end
    end

    // ---------------- Stage 3: drive, stall counter ----------------
    logic signed [ACC_W-1:0]            acc, scaled, olim;
    logic signed [psd_pkg::DRIVE_W-1:0] n_drive;
    logic signed [PD5_W-1:0]            prev5, olim5;
    logic [CNT_W-1:0]                   n_stall_count;
    logic                               n_locked;

    logic signed [psd_pkg::DRIVE_W-1:0] r_drive;
    logic [CNT_W-1:0]                   r_stall_count;
    logic                               r_locked;

    // Sum, floor-scale and clamp the drive
    always_comb begin
        acc    = ACC_W'(r_s2_prod_p) + ACC_W'(r_s2_prod_i) + ACC_W'(r_s2_prod_d);
        scaled = acc >>> psd_pkg::FRAC_BITS;
        olim   = ACC_W'($signed({1'b0, cfg.out_limit}));
        priority if (scaled > olim) begin
            n_drive = psd_pkg::DRIVE_W'(olim);
        end else if (scaled < -olim) begin
            n_drive = psd_pkg::DRIVE_W'(-olim);
        end else begin
            n_drive = psd_pkg::DRIVE_W'(scaled);
        end
    end

    // Stall detection on the previous drive, held in r_drive
    always_comb begin
        prev5         = PD5_W'(r_drive) * PD5_W'(psd_pkg::LIMIT_DIV);
        olim5         = PD5_W'($signed({1'b0, cfg.out_limit}));
        n_stall_count = r_stall_count;
        n_locked      = r_locked;
        if (r_s2_tgt_nz && !(prev5 < olim5)) begin
            priority if (r_s2_hit) begin
                if (r_stall_count < CNT_W'(STALL_COUNT_MAX)) begin
                    n_stall_count = r_stall_count + 1'b1;
                end
            end else if (r_stall_count != '0) begin
                n_stall_count = r_stall_count - 1'b1;
            end
            priority if (psd_pkg::THR_W'(n_stall_count) > cfg.lock_threshold) begin
                n_locked = 1'b1;
            end else if (psd_pkg::THR_W'(n_stall_count) < cfg.unlock_threshold) begin
                n_locked = 1'b0;
            end else begin
                n_locked = r_locked;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3          <= 1'b0;
            r_drive       <= '0;
            r_stall_count <= '0;
            r_locked      <= 1'b0;
        end else begin
            if (en3) begin
                r_v3 <= r_v2;
            end
            if (en3 && r_v2) begin
                r_drive       <= n_drive;
                r_stall_count <= n_stall_count;
                r_locked      <= n_locked;
            end
        end
    end

    assign m_axis_tvalid = r_v3;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, r_locked, r_drive};

    // ---------------- Checks ----------------
    // Input backpressure only when every stage holds a word
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_v1 && r_v2 && r_v3))
        else $error("input stalled with a free stage");

    // Stall counter moves by at most one per word
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_stall_count == $past(r_stall_count)
                         || r_stall_count == $past(r_stall_count) + 1'b1
                         || r_stall_count == $past(r_stall_count) - 1'b1))
        else $error("stall counter jumped");

    // Lock sets only above the lock threshold
    a_lock_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $rose(r_locked))
        |-> (psd_pkg::THR_W'(r_stall_count) > $past(cfg.lock_threshold)))
        else $error("locked set at or below lock threshold");

    // Lock clears only below the unlock threshold
    a_lock_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $fell(r_locked))
        |-> (psd_pkg::THR_W'(r_stall_count) < $past(cfg.unlock_threshold)))
        else $error("locked cleared at or above unlock threshold");

endmodule
